### hw/rtl/lir_pkg.sv
// ----------------------------------------------------------------------------
// lir_pkg: shared definitions of the linear interpolation resampler
// Rates, widths, divider constants and the queue entry passed front to back.
// ----------------------------------------------------------------------------
package lir_pkg;

  // Fixed source rate and the derived clamp limits of the output rate
  localparam int SOURCE_RATE = 55930;
  localparam int RATE_LOW    = SOURCE_RATE / 2 + 1;
  localparam int RATE_RESET  = 44100;

  // Blend arithmetic: weights are phase/256, the sum is divided by SOURCE_RATE/256
  localparam int WEIGHT_DIV = SOURCE_RATE / 256;
  localparam int GAIN       = 11;

  // Field and internal widths
  localparam int SAMPLE_W = 16;
  localparam int RATE_W   = 16;
  localparam int PHASE_W  = 17;
  localparam int WEIGHT_W = 8;
  localparam int OUT_W    = 20;
  localparam int PROD_W   = SAMPLE_W + WEIGHT_W + 1;
  localparam int MAG_W    = PROD_W - 1;
  localparam int QUO_W    = 17;

  // Reciprocal of WEIGHT_DIV, scaled by 2^RECIP_SHIFT (truncated)
  localparam int RECIP_SHIFT = 31;
  localparam int RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'(1) << RECIP_SHIFT) / WEIGHT_DIV);

  // Output range after gain
  localparam int OUT_MAX = 360448;

  // Decoupling queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Number of audio channels (left is lane 0, right is lane 1)
  localparam int LANES = 2;

  // One blend request: sample pair and weights for both channels
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] older_right;
    logic signed [SAMPLE_W-1:0] older_left;
    logic signed [SAMPLE_W-1:0] newer_right;
    logic signed [SAMPLE_W-1:0] newer_left;
    logic [WEIGHT_W-1:0]        w_older;
    logic [WEIGHT_W-1:0]        w_newer;
  } lir_entry_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } lir_qstat_t;

endpackage

### hw/rtl/lir_front.sv
// ----------------------------------------------------------------------------
// lir_front: phase tracking and slot classification
// Accepts source samples, advances the phase, and queues a blend request for
// every slot that is complete.
// ----------------------------------------------------------------------------
module lir_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lir_pkg::RATE_W-1:0]     cfg_wdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [2*lir_pkg::SAMPLE_W-1:0] s_axis_tdata,  // source_left, source_right
  input  lir_pkg::lir_qstat_t            qstat,
  output logic                           push_valid,
  output lir_pkg::lir_entry_t            push_entry
);

  logic [lir_pkg::RATE_W-1:0]          output_rate;
  logic [lir_pkg::PHASE_W-1:0]         phase;
  logic                                awaiting;
  logic signed [lir_pkg::SAMPLE_W-1:0] newer_left;
  logic signed [lir_pkg::SAMPLE_W-1:0] newer_right;

  logic [lir_pkg::RATE_W-1:0]  rate_use;
  logic [lir_pkg::RATE_W-1:0]  step;
  logic signed [lir_pkg::PHASE_W:0] dec;
  logic signed [lir_pkg::PHASE_W:0] wrapped;
  logic                        underflow;
  logic [lir_pkg::PHASE_W-1:0] phase_emit;
  logic [lir_pkg::PHASE_W-1:0] phase_rest;
  logic                        accept;

  // Clamp the rate so the phase stays in range
  always_comb begin
    rate_use = output_rate;
    if (output_rate < lir_pkg::RATE_W'(lir_pkg::RATE_LOW)) begin
      rate_use = lir_pkg::RATE_W'(lir_pkg::RATE_LOW);
    end else if (output_rate > lir_pkg::RATE_W'(lir_pkg::SOURCE_RATE)) begin
      rate_use = lir_pkg::RATE_W'(lir_pkg::SOURCE_RATE);
    end
  end

  // Lower the phase by one slot and detect underflow
  always_comb begin
    step      = lir_pkg::RATE_W'(lir_pkg::SOURCE_RATE) - rate_use;
    dec       = $signed({1'b0, phase}) - $signed({2'b00, step});
    wrapped   = dec + $signed({2'b00, rate_use});
    underflow = dec[lir_pkg::PHASE_W];
  end

  // Build the blend request from the phase that the slot ends with
  always_comb begin
    s_axis_tready = !qstat.full;
    accept        = s_axis_tvalid && s_axis_tready;
    phase_emit    = awaiting ? phase : dec[lir_pkg::PHASE_W-1:0];
    phase_rest    = lir_pkg::PHASE_W'(lir_pkg::SOURCE_RATE) - phase_emit;
    push_valid    = accept && (awaiting || !underflow);
    push_entry.older_left  = newer_left;
    push_entry.older_right = newer_right;
    push_entry.newer_left  = $signed(s_axis_tdata[lir_pkg::SAMPLE_W-1:0]);
    push_entry.newer_right = $signed(s_axis_tdata[2*lir_pkg::SAMPLE_W-1:lir_pkg::SAMPLE_W]);
    push_entry.w_older     = phase_emit[15:8];
    push_entry.w_newer     = phase_rest[15:8];
  end

  // Hold the rate, phase and sample state
  always_ff @(posedge clk) begin
    if (rst) begin
      output_rate <= lir_pkg::RATE_W'(lir_pkg::RATE_RESET);
      phase       <= '0;
      awaiting    <= 1'b0;
      newer_left  <= '0;
      newer_right <= '0;
    end else begin
      if (cfg_we) begin
        output_rate <= cfg_wdata;
      end
      if (accept) begin
        newer_left  <= push_entry.newer_left;
        newer_right <= push_entry.newer_right;
        if (awaiting) begin
          awaiting <= 1'b0;
        end else if (underflow) begin
          phase    <= wrapped[lir_pkg::PHASE_W-1:0];
          awaiting <= 1'b1;
        end else begin
          phase <= dec[lir_pkg::PHASE_W-1:0];
        end
      end
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase < lir_pkg::PHASE_W'(lir_pkg::SOURCE_RATE))
    else $error("phase left its range");

  a_extra_emits: assert property (@(posedge clk) disable iff (rst)
    (accept && awaiting) |-> push_valid)
    else $error("second sample of a slot did not emit");

  a_underflow_waits: assert property (@(posedge clk) disable iff (rst)
    (accept && !awaiting && !push_valid) |=> awaiting)
    else $error("underflowing slot did not wait for its second sample");

endmodule

### hw/rtl/lir_queue.sv
// ----------------------------------------------------------------------------
// lir_queue: request queue between front and back
// Small register queue of blend requests; lets either side stall on its own.
// ----------------------------------------------------------------------------
module lir_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  input  lir_pkg::lir_entry_t push_entry,
  input  logic                pop,
  output lir_pkg::lir_entry_t head,
  output lir_pkg::lir_qstat_t qstat
);

  lir_pkg::lir_entry_t           slots [lir_pkg::QUEUE_DEPTH];
  logic [lir_pkg::QPTR_W-1:0]    wr_ptr;
  logic [lir_pkg::QPTR_W-1:0]    rd_ptr;
  logic [lir_pkg::QCNT_W-1:0]    count;
  logic                          do_push;
  logic                          do_pop;

  // Status and head of queue
  always_comb begin
    qstat.full  = (count == lir_pkg::QCNT_W'(lir_pkg::QUEUE_DEPTH));
    qstat.empty = (count == '0);
    do_push     = push_valid && !qstat.full;
    do_pop      = pop && !qstat.empty;
    head        = slots[rd_ptr];
  end

  // Store requests
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_lost_push: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> !qstat.full)
    else $error("request pushed into a full queue");

endmodule

### hw/rtl/lir_back.sv
// ----------------------------------------------------------------------------
// lir_back: blend pipeline
// Weights both samples, divides by SOURCE_RATE/256 through a reciprocal with
// one correction step, applies the gain and holds the result for the sink.
// ----------------------------------------------------------------------------
module lir_back (
  input  logic                        clk,
  input  logic                        rst,
  input  lir_pkg::lir_entry_t         head,
  input  lir_pkg::lir_qstat_t         qstat,
  output logic                        pop,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [2*lir_pkg::OUT_W-1:0] m_axis_tdata  // out_left, out_right
);

  localparam int PW = lir_pkg::PROD_W;
  localparam int MW = lir_pkg::MAG_W;
  localparam int QW = lir_pkg::QUO_W;
  localparam int WW = MW + lir_pkg::RECIP_W;

  localparam logic signed [lir_pkg::OUT_W-1:0] OUT_HI = lir_pkg::OUT_W'(lir_pkg::OUT_MAX);
  localparam logic signed [lir_pkg::OUT_W-1:0] OUT_LO = -OUT_HI;

  logic en;
  logic v1, v2, v3, v4;

  logic signed [PW-1:0]          prod_older [lir_pkg::LANES];
  logic signed [PW-1:0]          prod_newer [lir_pkg::LANES];
  logic [MW-1:0]                 mag2 [lir_pkg::LANES];
  logic [MW-1:0]                 mag3 [lir_pkg::LANES];
  logic [QW-1:0]                 quo3 [lir_pkg::LANES];
  logic [QW-1:0]                 quo4 [lir_pkg::LANES];
  logic                          neg2 [lir_pkg::LANES];
  logic                          neg3 [lir_pkg::LANES];
  logic                          neg4 [lir_pkg::LANES];
  logic signed [lir_pkg::OUT_W-1:0] out_val [lir_pkg::LANES];

  logic signed [lir_pkg::SAMPLE_W-1:0] older_s [lir_pkg::LANES];
  logic signed [lir_pkg::SAMPLE_W-1:0] newer_s [lir_pkg::LANES];
  logic signed [PW-1:0]          sum_c  [lir_pkg::LANES];
  logic [WW-1:0]                 wide_c [lir_pkg::LANES];
  logic [PW-1:0]                 back_c [lir_pkg::LANES];
  logic [PW-1:0]                 rem_c  [lir_pkg::LANES];
  logic signed [QW:0]            sgn_c  [lir_pkg::LANES];
  logic signed [QW+4:0]          scl_c  [lir_pkg::LANES];

  // Advance the whole pipe while the output register is free or drains
  always_comb begin
    en  = !m_axis_tvalid || m_axis_tready;
    pop = en && !qstat.empty;
    older_s[0] = head.older_left;
    older_s[1] = head.older_right;
    newer_s[0] = head.newer_left;
    newer_s[1] = head.newer_right;
  end

  // Per-lane arithmetic between stages
  always_comb begin
    for (int i = 0; i < lir_pkg::LANES; i++) begin
      sum_c[i]  = prod_older[i] + prod_newer[i];
      wide_c[i] = WW'(mag2[i]) * WW'(lir_pkg::RECIP);
      back_c[i] = PW'(quo3[i]) * PW'(lir_pkg::WEIGHT_DIV);
      rem_c[i]  = {1'b0, mag3[i]} - back_c[i];
      sgn_c[i]  = neg4[i] ? -$signed({1'b0, quo4[i]}) : $signed({1'b0, quo4[i]});
      scl_c[i]  = (QW+5)'(sgn_c[i]) * (QW+5)'(lir_pkg::GAIN);
    end
  end

  // Stage valids and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      v4            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      v1            <= pop;
      v2            <= v1;
      v3            <= v2;
      v4            <= v3;
      m_axis_tvalid <= v4;
    end
  end

  // Stage payloads: weight, magnitude, reciprocal, correction, gain
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < lir_pkg::LANES; i++) begin
        prod_older[i] <= older_s[i] * $signed({1'b0, head.w_older});
        prod_newer[i] <= newer_s[i] * $signed({1'b0, head.w_newer});
        neg2[i]       <= sum_c[i][PW-1];
        mag2[i]       <= sum_c[i][PW-1] ? MW'(-sum_c[i]) : MW'(sum_c[i]);
        neg3[i]       <= neg2[i];
        mag3[i]       <= mag2[i];
        quo3[i]       <= wide_c[i][lir_pkg::RECIP_SHIFT +: QW];
        neg4[i]       <= neg3[i];
        quo4[i]       <= (rem_c[i] >= PW'(lir_pkg::WEIGHT_DIV)) ? quo3[i] + 1'b1 : quo3[i];
        out_val[i]    <= scl_c[i][lir_pkg::OUT_W-1:0];
      end
    end
  end

  assign m_axis_tdata = {out_val[1], out_val[0]};

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_val[0] <= OUT_HI && out_val[0] >= OUT_LO &&
                       out_val[1] <= OUT_HI && out_val[1] >= OUT_LO))
    else $error("blend result out of range");

endmodule

### hw/rtl/linear_interp_audio_resampler_core.sv
// ----------------------------------------------------------------------------
// linear_interp_audio_resampler_core: stereo linear interpolation resampler
// Front tracks phase and samples, a short queue holds blend requests, the
// back pipeline computes the weighted, divided and amplified output pair.
// ----------------------------------------------------------------------------
//   channel   dir   payload                         handshake
//   s_axis    in    source_left, source_right       tvalid/tready
//   m_axis    out   out_left, out_right             tvalid/tready
//   cfg       in    output_rate                     cfg_we, no wait
//
// One source request is accepted per cycle while the queue is not full; the
// front updates phase and samples on acceptance. A result passes the queue
// and the weight, magnitude, reciprocal, correction and gain stages.
// Synchronous reset clears the phase, samples and queue; the rate returns
// to 44100. A stalled sink freezes the back pipe; the front keeps accepting
// until the four-entry queue is full.
// ----------------------------------------------------------------------------
module linear_interp_audio_resampler_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lir_pkg::RATE_W-1:0]     cfg_wdata,      // output_rate
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [2*lir_pkg::SAMPLE_W-1:0] s_axis_tdata,   // source_left, source_right
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [2*lir_pkg::OUT_W-1:0]    m_axis_tdata    // out_left, out_right
);

  logic                push_valid;
  lir_pkg::lir_entry_t push_entry;
  lir_pkg::lir_entry_t head;
  lir_pkg::lir_qstat_t qstat;
  logic                pop;

  // Classify source samples and queue blend requests
  lir_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .qstat         (qstat),
    .push_valid    (push_valid),
    .push_entry    (push_entry)
  );

  // Decouple front and back
  lir_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  // Compute and deliver results
  lir_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .qstat         (qstat),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for linear_interp_audio_resampler_core
// Streams stereo source samples through the resampler under random source and
// sink pacing, tracks phase and sample pairs in a local model of the
// converter, and compares every output pair against the predicted value.
// Rate writes happen only while the block is idle and cover the clamp limits.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT      = 1000000;
  localparam int DRAIN_LIMIT      = 20000;
  localparam int SETTLE_CYCLES    = 10;
  localparam int SINK_HOLD_CYCLES = 300;
  localparam int WEIGHT_STEP      = 256;
  localparam int RANDOM_BLOCKS    = 11;
  localparam int BLOCK_ITEMS      = 100;
  localparam int PRESSURE_ITEMS   = 40;

  localparam logic signed [lir_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [lir_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [lir_pkg::OUT_W-1:0] out_right;
    logic signed [lir_pkg::OUT_W-1:0] out_left;
  } mix_pair_t;

  logic                             clk;
  logic                             rst           = 1'b1;
  logic                             cfg_we        = 1'b0;
  logic [lir_pkg::RATE_W-1:0]       cfg_wdata     = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [2*lir_pkg::SAMPLE_W-1:0]   s_axis_tdata  = '0;   // source_left, source_right
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [2*lir_pkg::OUT_W-1:0]      m_axis_tdata;         // out_left, out_right

  // Local model of the converter
  logic [lir_pkg::RATE_W-1:0]          rate_reg;
  int                                  phase_acc;
  logic signed [lir_pkg::SAMPLE_W-1:0] older_l, older_r, newer_l, newer_r;
  bit                                  slot_awaiting;
  mix_pair_t                           pending_mix_q[$];

  int  mismatch_count = 0;
  int  cycle_count    = 0;
  bit  src_steady     = 1'b0;
  bit  sink_hold_req  = 1'b0;

  linear_interp_audio_resampler_core DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [lir_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return SAMPLE_MAX;
          1: return SAMPLE_MIN;
          2: return '0;
          default: return -16'sd1;
        endcase
      end
      1: return 16'($urandom_range(0, 64)) - 16'sd32;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [lir_pkg::RATE_W-1:0] pick_rate();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 2) begin
      case ($urandom_range(0, 5))
        0: return lir_pkg::RATE_W'(lir_pkg::RATE_LOW);
        1: return lir_pkg::RATE_W'(lir_pkg::SOURCE_RATE);
        2: return lir_pkg::RATE_W'(lir_pkg::RATE_LOW - 1);
        3: return lir_pkg::RATE_W'(lir_pkg::SOURCE_RATE + 1);
        4: return '0;
        default: return '1;
      endcase
    end
    if (roll < 9) begin
      return lir_pkg::RATE_W'($urandom_range(lir_pkg::RATE_LOW, lir_pkg::SOURCE_RATE));
    end
    return lir_pkg::RATE_W'($urandom());
  endfunction

  function automatic int clamped_rate();
    int r;
    r = int'(rate_reg);
    if (r < lir_pkg::RATE_LOW) r = lir_pkg::RATE_LOW;
    if (r > lir_pkg::SOURCE_RATE) r = lir_pkg::SOURCE_RATE;
    return r;
  endfunction

  // Weighted blend of the sample pair, truncating division, times the gain
  function automatic logic signed [lir_pkg::OUT_W-1:0] weigh(
    input logic signed [lir_pkg::SAMPLE_W-1:0] older,
    input logic signed [lir_pkg::SAMPLE_W-1:0] newer,
    input int                                  ph
  );
    longint w_old, w_new, acc, quo;
    w_old = ph / WEIGHT_STEP;
    w_new = (lir_pkg::SOURCE_RATE - ph) / WEIGHT_STEP;
    acc   = longint'(older) * w_old + longint'(newer) * w_new;
    quo   = acc / lir_pkg::WEIGHT_DIV;
    return lir_pkg::OUT_W'(quo * lir_pkg::GAIN);
  endfunction

  // Advance the converter by one source sample, queue the output if any
  task automatic resample_step(
    input logic signed [lir_pkg::SAMPLE_W-1:0] left_in,
    input logic signed [lir_pkg::SAMPLE_W-1:0] right_in
  );
    int        rate_now;
    mix_pair_t res;
    older_l = newer_l;
    older_r = newer_r;
    newer_l = left_in;
    newer_r = right_in;
    if (slot_awaiting) begin
      slot_awaiting = 1'b0;
    end else begin
      rate_now  = clamped_rate();
      phase_acc = phase_acc - (lir_pkg::SOURCE_RATE - rate_now);
      // Underflow: this slot needs one more sample before it emits
      if (phase_acc < 0) begin
        phase_acc     = phase_acc + rate_now;
        slot_awaiting = 1'b1;
        return;
      end
    end
    res.out_left  = weigh(older_l, newer_l, phase_acc);
    res.out_right = weigh(older_r, newer_r, phase_acc);
    pending_mix_q.push_back(res);
  endtask

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // Track accepted rate writes and source requests
  always @(posedge clk) begin
    if (rst) begin
      rate_reg      = lir_pkg::RATE_W'(lir_pkg::RATE_RESET);
      phase_acc     = 0;
      older_l       = '0;
      older_r       = '0;
      newer_l       = '0;
      newer_r       = '0;
      slot_awaiting = 1'b0;
      pending_mix_q.delete();
    end else begin
      if (cfg_we) rate_reg = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready)
        resample_step(s_axis_tdata[lir_pkg::SAMPLE_W-1:0],
                      s_axis_tdata[2*lir_pkg::SAMPLE_W-1:lir_pkg::SAMPLE_W]);
    end
  end

  // Compare each output request with the oldest prediction
  always @(posedge clk) begin
    mix_pair_t want, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_mix_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected output %0d / %0d", got.out_left, got.out_right));
      end else begin
        want = pending_mix_q.pop_front();
        if (got.out_left !== want.out_left)
          flag_mismatch($sformatf("out_left %0d, expected %0d", got.out_left, want.out_left));
        if (got.out_right !== want.out_right)
          flag_mismatch($sformatf("out_right %0d, expected %0d", got.out_right,
                                  want.out_right));
      end
    end
  end

  // Pace the sink: random ready stretches and gaps, or a long hold on request
  initial begin : sink_pacing
    int stretch_left;
    bit ready_next;
    stretch_left = 0;
    ready_next   = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        ready_next    = 1'b0;
        stretch_left  = SINK_HOLD_CYCLES;
      end else if (stretch_left == 0) begin
        stretch_left = ready_next ? pick_gap() : 0;
        if (stretch_left > 0) begin
          ready_next = 1'b0;
        end else begin
          ready_next   = 1'b1;
          stretch_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                    : $urandom_range(1, 12);
        end
      end
      stretch_left--;
      m_axis_tready <= ready_next;
    end
  end

  // Offer one source request, hold it until accepted
  task automatic send_sample(
    input logic signed [lir_pkg::SAMPLE_W-1:0] left_in,
    input logic signed [lir_pkg::SAMPLE_W-1:0] right_in
  );
    int gap;
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {right_in, left_in};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic write_rate(input logic [lir_pkg::RATE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Stop offering, wait for every predicted output, then let the front settle
  task automatic drain_results();
    int waited;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending_mix_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_mix_q.size() != 0) begin
      flag_mismatch($sformatf("%0d outputs never arrived", pending_mix_q.size()));
      pending_mix_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reset rate, sample extremes
  task automatic test_reset_rate();
    send_sample('0, '0);
    send_sample(SAMPLE_MAX, SAMPLE_MIN);
    send_sample(SAMPLE_MIN, SAMPLE_MAX);
    send_sample(-16'sd1, 16'sd1);
    send_sample(SAMPLE_MAX, SAMPLE_MAX);
    drain_results();
  endtask

  // Full rate holds the phase: every source sample then emits a blend at that phase
  task automatic test_full_rate();
    write_rate(lir_pkg::RATE_W'(lir_pkg::SOURCE_RATE));
    send_sample(SAMPLE_MIN, SAMPLE_MIN);
    send_sample(SAMPLE_MAX, SAMPLE_MIN);
    send_sample(16'sd1, -16'sd1);
    drain_results();
  endtask

  // Rates below and above the legal range clamp to the limits, then the low limit
  task automatic test_rate_clamp();
    write_rate('0);
    send_sample(SAMPLE_MIN, SAMPLE_MAX);
    send_sample(SAMPLE_MAX, SAMPLE_MIN);
    drain_results();
    write_rate('1);
    send_sample(pick_sample(), pick_sample());
    send_sample(pick_sample(), pick_sample());
    drain_results();
    write_rate(lir_pkg::RATE_W'(lir_pkg::RATE_LOW));
    send_sample(SAMPLE_MAX, -16'sd1);
    send_sample(-16'sd1, SAMPLE_MAX);
    drain_results();
  endtask

  // Change the rate while a slot waits for its second sample
  task automatic test_write_while_awaiting();
    int tries;
    tries = 0;
    while (!slot_awaiting && tries < 4) begin
      send_sample(pick_sample(), pick_sample());
      drain_results();
      tries++;
    end
    write_rate(16'd50000);
    send_sample(SAMPLE_MIN, SAMPLE_MAX);
    send_sample(pick_sample(), pick_sample());
    drain_results();
  endtask

  // Hold the sink off while the source keeps offering, so the input stalls
  task automatic test_sink_backpressure();
    src_steady    = 1'b1;
    sink_hold_req = 1'b1;
    repeat (PRESSURE_ITEMS) send_sample(pick_sample(), pick_sample());
    src_steady = 1'b0;
    drain_results();
  endtask

  // Random samples in blocks, a new rate between blocks
  task automatic test_random_traffic();
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      write_rate(pick_rate());
      src_steady = (blk % 4 == 3);
      repeat (BLOCK_ITEMS) send_sample(pick_sample(), pick_sample());
      src_steady = 1'b0;
      drain_results();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_rate();
    test_full_rate();
    test_rate_clamp();
    test_write_while_awaiting();
    test_sink_backpressure();
    test_random_traffic();
    if (mismatch_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/lir_pkg.sv
hw/rtl/lir_front.sv
hw/rtl/lir_queue.sv
hw/rtl/lir_back.sv
hw/rtl/linear_interp_audio_resampler_core.sv
verif/testbench.sv
